// ----- src/scb_pkg.sv -----
// Shared constants and types for the span coverage buffer.
package scb_pkg;

  localparam int unsigned SCREEN_WIDTH  = 320;
  localparam int unsigned MAX_INTERVALS = 64;
  localparam int unsigned COL_W         = 9;
  localparam int unsigned CNT_W         = $clog2(MAX_INTERVALS + 1);

  typedef logic [COL_W-1:0] col_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam col_t SCREEN_END = col_t'(SCREEN_WIDTH);
  localparam cnt_t CNT_MAX    = cnt_t'(MAX_INTERVALS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;
    logic wr1;
    cnt_t pos1;
    col_t s1;
    col_t e1;
    logic wr2;
    cnt_t pos2;
    col_t s2;
    col_t e2;
  } cell_cmd_t;

endpackage

// ----- src/span_coverage_buffer.sv -----
// Top level: span coverage buffer built from a chain of interval cells.
// The undrawn intervals sit in a row of cells, head first. A span item walks the
// set once: each cycle, unless the result port stalls, the head interval leaves the
// chain, is compared with the span and is pushed back at the tail (trimmed, split or
// dropped on write_back, kept whole on pool overflow). Pieces come out in ascending
// column order, the final result of each item carrying tlast.
module span_coverage_buffer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [23:0] s_tdata_i,   // [8:0] span_start, [17:9] span_end, [18] write_back
  input  logic        s_tuser_i,   // kind
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [23:0] m_tdata_o,   // [8:0] piece_start, [17:9] piece_end
  output logic [2:0]  m_tuser_o,   // [0] has_piece, [1] screen_done, [2] pool_overflow
  output logic        m_tlast_o
);

  localparam int unsigned N = scb_pkg::MAX_INTERVALS;

  scb_pkg::state_e state_q, state_d;
  scb_pkg::cnt_t   cnt_q, cnt_d, rem_q, rem_d, n_q, n_d;
  scb_pkg::col_t   a_q, a_d, b_q, b_d;
  logic            wb_q, wb_d, rst_item_q, rst_item_d, done_q, done_d;
  logic            pend_v_q, pend_v_d, pend_ovf_q, pend_ovf_d;
  scb_pkg::col_t   pend_s_q, pend_s_d, pend_e_q, pend_e_d;

  logic            out_v_q, out_v_d, out_has_q, out_has_d, out_last_q, out_last_d;
  logic            out_done_q, out_done_d, out_ovf_q, out_ovf_d;
  scb_pkg::col_t   out_s_q, out_s_d, out_e_q, out_e_d;

  scb_pkg::col_t   cs [N];
  scb_pkg::col_t   ce [N];
  scb_pkg::col_t   ns [N];
  scb_pkg::col_t   ne [N];
  scb_pkg::cell_cmd_t cmd;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      if (g == N - 1) begin : g_tail
        assign ns[g] = '0;
        assign ne[g] = '0;
      end else begin : g_mid
        assign ns[g] = cs[g+1];
        assign ne[g] = ce[g+1];
      end
      scb_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .idx_i       (scb_pkg::cnt_t'(g)),
        .cmd_i       (cmd),
        .nxt_start_i (ns[g]),
        .nxt_end_i   (ne[g]),
        .start_o     (cs[g]),
        .end_o       (ce[g])
      );
    end
  endgenerate

  logic          out_free, accept, hit, left, right;
  scb_pkg::col_t hs, he, ps, pe;
  scb_pkg::cnt_t pos;

  assign out_free   = !out_v_q || m_tready_i;
  assign s_tready_o = (state_q == scb_pkg::ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;

  assign hs    = cs[0];
  assign he    = ce[0];
  assign hit   = (a_q < b_q) && (he > a_q) && (hs < b_q);
  assign left  = hs < a_q;
  assign right = he > b_q;
  assign ps    = (hs > a_q) ? hs : a_q;
  assign pe    = (he < b_q) ? he : b_q;
  assign pos   = rem_q - scb_pkg::cnt_t'(1) + n_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    n_d        = n_q;
    a_d        = a_q;
    b_d        = b_q;
    wb_d       = wb_q;
    rst_item_d = rst_item_q;
    done_d     = done_q;
    pend_v_d   = pend_v_q;
    pend_ovf_d = pend_ovf_q;
    pend_s_d   = pend_s_q;
    pend_e_d   = pend_e_q;
    out_v_d    = out_v_q && !m_tready_i;
    out_has_d  = out_has_q;
    out_last_d = out_last_q;
    out_done_d = out_done_q;
    out_ovf_d  = out_ovf_q;
    out_s_d    = out_s_q;
    out_e_d    = out_e_q;
    cmd        = '0;

    case (state_q)
      scb_pkg::ST_IDLE: begin
        if (accept) begin
          a_d        = s_tdata_i[8:0];
          b_d        = s_tdata_i[17:9];
          wb_d       = s_tdata_i[18];
          rst_item_d = !s_tuser_i;
          done_d     = s_tuser_i && (cnt_q == '0);
          rem_d      = cnt_q;
          n_d        = '0;
          pend_v_d   = 1'b0;
          if (!s_tuser_i) begin
            cmd.wr1  = 1'b1;
            cmd.pos1 = '0;
            cmd.s1   = '0;
            cmd.e1   = scb_pkg::SCREEN_END;
            cnt_d    = scb_pkg::cnt_t'(1);
            state_d  = scb_pkg::ST_FIN;
          end else if (cnt_q == '0) begin
            state_d = scb_pkg::ST_FIN;
          end else begin
            state_d = scb_pkg::ST_RUN;
          end
        end
      end
      scb_pkg::ST_RUN: begin
        if (out_free) begin
          if (rem_q == '0) begin
            cnt_d   = n_q;
            state_d = scb_pkg::ST_FIN;
          end else begin
            // pop the head, push its remainder(s) at the tail
            cmd.shift = 1'b1;
            cmd.wr1   = 1'b1;
            cmd.pos1  = pos;
            cmd.s1    = hs;
            cmd.e1    = he;
            cmd.pos2  = pos + scb_pkg::cnt_t'(1);
            cmd.s2    = b_q;
            cmd.e2    = he;
            pend_ovf_d = pend_ovf_q;
            if (hit) begin
              if (pend_v_q) begin
                out_v_d    = 1'b1;
                out_has_d  = 1'b1;
                out_last_d = 1'b0;
                out_done_d = 1'b0;
                out_ovf_d  = pend_ovf_q;
                out_s_d    = pend_s_q;
                out_e_d    = pend_e_q;
              end
              pend_v_d   = 1'b1;
              pend_s_d   = ps;
              pend_e_d   = pe;
              pend_ovf_d = 1'b0;
              if (wb_q) begin
                if (left && right && cnt_q >= scb_pkg::CNT_MAX) begin
                  pend_ovf_d = 1'b1;
                end else if (left) begin
                  cmd.e1  = a_q;
                  cmd.wr2 = right;
                end else if (right) begin
                  cmd.s1 = b_q;
                end else begin
                  cmd.wr1 = 1'b0;
                end
              end
            end
            rem_d = rem_q - scb_pkg::cnt_t'(1);
            n_d   = n_q + scb_pkg::cnt_t'(cmd.wr1) + scb_pkg::cnt_t'(cmd.wr2);
          end
        end
      end
      scb_pkg::ST_FIN: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_last_d = 1'b1;
          out_done_d = done_q;
          out_has_d  = pend_v_q && !rst_item_q && !done_q;
          out_ovf_d  = out_has_d && pend_ovf_q;
          out_s_d    = out_has_d ? pend_s_q : '0;
          out_e_d    = out_has_d ? pend_e_q : '0;
          pend_v_d   = 1'b0;
          state_d    = scb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = scb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= scb_pkg::ST_IDLE;
      cnt_q    <= scb_pkg::cnt_t'(1);
      rem_q    <= '0;
      n_q      <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      n_q      <= n_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    wb_q       <= wb_d;
    rst_item_q <= rst_item_d;
    done_q     <= done_d;
    pend_ovf_q <= pend_ovf_d;
    pend_s_q   <= pend_s_d;
    pend_e_q   <= pend_e_d;
    out_has_q  <= out_has_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
    out_ovf_q  <= out_ovf_d;
    out_s_q    <= out_s_d;
    out_e_q    <= out_e_d;
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = {6'd0, out_e_q, out_s_q};
  assign m_tuser_o  = {out_ovf_q, out_done_q, out_has_q};
  assign m_tlast_o  = out_last_q;

endmodule

// ----- src/scb_cell.sv -----
// One interval slot of the chain: shifts toward the head or loads a pushed interval.
module scb_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scb_pkg::cnt_t       idx_i,
  input  scb_pkg::cell_cmd_t  cmd_i,
  input  scb_pkg::col_t       nxt_start_i,
  input  scb_pkg::col_t       nxt_end_i,
  output scb_pkg::col_t       start_o,
  output scb_pkg::col_t       end_o
);

  scb_pkg::col_t start_q, start_d, end_q, end_d;

  always_comb begin
    start_d = start_q;
    end_d   = end_q;
    if (cmd_i.wr1 && cmd_i.pos1 == idx_i) begin
      start_d = cmd_i.s1;
      end_d   = cmd_i.e1;
    end else if (cmd_i.wr2 && cmd_i.pos2 == idx_i) begin
      start_d = cmd_i.s2;
      end_d   = cmd_i.e2;
    end else if (cmd_i.shift) begin
      start_d = nxt_start_i;
      end_d   = nxt_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= scb_pkg::SCREEN_END;
    end else begin
      start_q <= start_d;
      end_q   <= end_d;
    end
  end

  assign start_o = start_q;
  assign end_o   = end_q;

endmodule

// ----- dv/span_coverage_buffer_tb.sv -----
// Testbench for span_coverage_buffer: directed table plus random spans, checked against a predictor.
module span_coverage_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_RANDOM    = 104;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef enum logic {KIND_CLEAR = 1'b0, KIND_SPAN = 1'b1} kind_e;

  typedef struct {
    kind_e         kind;
    scb_pkg::col_t a;
    scb_pkg::col_t b;
    logic          wb;
  } span_req_t;

  typedef struct packed {
    logic          has;
    scb_pkg::col_t ps;
    scb_pkg::col_t pe;
    logic          last;
    logic          done;
    logic          ovf;
  } piece_t;

  // directed row; chk set when the single expected piece is typed in
  typedef struct {
    span_req_t req;
    logic      chk;
    piece_t    want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [23:0] s_tdata_i = '0;
  logic        s_tuser_i = 1'b0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [23:0] m_tdata_o;
  logic [2:0]  m_tuser_o;
  logic        m_tlast_o;

  span_coverage_buffer dut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state: undrawn interval set
  scb_pkg::col_t undrawn_s[$];
  scb_pkg::col_t undrawn_e[$];
  piece_t pending_pieces[$];
  piece_t last_pred;
  int unsigned errors, n_items, n_pieces, n_ovf, n_done, cycles;
  logic   hold_off = 1'b0;

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch %0s: got %0d want %0d (piece %0d)", what, got, want, n_pieces);
    errors++;
  endtask

  function automatic piece_t mk(input logic has, input scb_pkg::col_t ps,
                                input scb_pkg::col_t pe,
                                input logic done, input logic ovf, input logic last);
    piece_t p;
    p.has = has; p.ps = ps; p.pe = pe; p.done = done; p.ovf = ovf; p.last = last;
    return p;
  endfunction

  task automatic predict_span(input span_req_t r);
    scb_pkg::col_t ns[$];
    scb_pkg::col_t ne[$];
    piece_t        outp[$];
    int            cnt;
    scb_pkg::col_t s, e;
    logic          lft, rgt, ovf;
    if (r.kind == KIND_CLEAR) begin
      undrawn_s = '{scb_pkg::col_t'(0)};
      undrawn_e = '{scb_pkg::SCREEN_END};
      pending_pieces.push_back(mk(0, 0, 0, 0, 0, 1));
      return;
    end
    cnt = undrawn_s.size();
    if (cnt == 0) begin
      pending_pieces.push_back(mk(0, 0, 0, 1, 0, 1));
      n_done++;
      return;
    end
    for (int i = 0; i < cnt; i++) begin
      s = undrawn_s[i];
      e = undrawn_e[i];
      if (r.a >= r.b || e <= r.a || s >= r.b) begin
        ns.push_back(s); ne.push_back(e);
        continue;
      end
      ovf = 1'b0;
      if (r.wb) begin
        lft = s < r.a;
        rgt = e > r.b;
        if (lft && rgt && cnt >= scb_pkg::MAX_INTERVALS) begin
          ovf = 1'b1;
          ns.push_back(s); ne.push_back(e);
        end else begin
          if (lft) begin ns.push_back(s); ne.push_back(r.a); end
          if (rgt) begin ns.push_back(r.b); ne.push_back(e); end
        end
      end else begin
        ns.push_back(s); ne.push_back(e);
      end
      outp.push_back(mk(1, (s > r.a) ? s : r.a, (e < r.b) ? e : r.b, 0, ovf, 0));
      if (ovf) n_ovf++;
    end
    if (r.wb) begin
      while (ns.size() > scb_pkg::MAX_INTERVALS) begin
        void'(ns.pop_back()); void'(ne.pop_back());
      end
      undrawn_s = ns;
      undrawn_e = ne;
    end
    if (outp.size() == 0) outp.push_back(mk(0, 0, 0, 0, 0, 1));
    outp[outp.size()-1].last = 1'b1;
    foreach (outp[k]) pending_pieces.push_back(outp[k]);
  endtask

  task automatic send(input span_req_t r);
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= r.kind;
    s_tdata_i  <= {5'b0, r.wb, r.b, r.a};
    do @(posedge clk_i); while (!s_tready_o);
    predict_span(r);
    last_pred = pending_pieces[$];
    n_items++;
    if ($urandom_range(0, 3) == 0) begin
      s_tvalid_i <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(5, 40)) @(posedge clk_i);
      else repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  function automatic span_req_t rq(input kind_e k, input int a, input int b, input logic wb);
    span_req_t r;
    r.kind = k; r.a = scb_pkg::col_t'(a); r.b = scb_pkg::col_t'(b); r.wb = wb;
    return r;
  endfunction

  // receiver: random stalls plus an externally requested hold-off
  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) m_tready_i <= 1'b0;
    else if ($urandom_range(0, 3) == 0) m_tready_i <= 1'b0;
    else m_tready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    piece_t w;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      n_pieces++;
      if (pending_pieces.size() == 0) begin
        $display("unexpected piece %0d", n_pieces);
        errors++;
      end else begin
        w = pending_pieces.pop_front();
        if (m_tuser_o[0] !== w.has) report("has_piece", m_tuser_o[0], w.has);
        if (m_tdata_o[8:0] !== w.ps) report("piece_start", m_tdata_o[8:0], w.ps);
        if (m_tdata_o[17:9] !== w.pe) report("piece_end", m_tdata_o[17:9], w.pe);
        if (m_tlast_o !== w.last) report("last", m_tlast_o, w.last);
        if (m_tuser_o[1] !== w.done) report("screen_done", m_tuser_o[1], w.done);
        if (m_tuser_o[2] !== w.ovf) report("pool_overflow", m_tuser_o[2], w.ovf);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // long receiver stall while the sender keeps offering items
  task automatic stall_receiver();
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  endtask

  dir_row_t dir_tab[$];

  initial begin
    span_req_t r;
    int        a, w, mode;
    undrawn_s = '{scb_pkg::col_t'(0)};
    undrawn_e = '{scb_pkg::SCREEN_END};
    dir_tab = '{
      '{rq(KIND_CLEAR, 511, 511, 1), 1, mk(0, 0, 0, 0, 0, 1)},
      '{rq(KIND_SPAN, 0, 320, 0), 1, mk(1, 0, 320, 0, 0, 1)},
      '{rq(KIND_SPAN, 10, 10, 1), 1, mk(0, 0, 0, 0, 0, 1)},
      '{rq(KIND_SPAN, 300, 20, 1), 1, mk(0, 0, 0, 0, 0, 1)},
      '{rq(KIND_SPAN, 320, 511, 1), 1, mk(0, 0, 0, 0, 0, 1)},
      '{rq(KIND_SPAN, 100, 200, 1), 1, mk(1, 100, 200, 0, 0, 1)},
      '{rq(KIND_SPAN, 0, 511, 0), 0, mk(0, 0, 0, 0, 0, 0)},
      '{rq(KIND_SPAN, 0, 50, 1), 0, mk(0, 0, 0, 0, 0, 0)},
      '{rq(KIND_SPAN, 300, 511, 1), 0, mk(0, 0, 0, 0, 0, 0)},
      '{rq(KIND_SPAN, 150, 250, 1), 0, mk(0, 0, 0, 0, 0, 0)},
      '{rq(KIND_SPAN, 0, 511, 1), 0, mk(0, 0, 0, 0, 0, 0)},
      '{rq(KIND_SPAN, 0, 511, 1), 1, mk(0, 0, 0, 1, 0, 1)},
      '{rq(KIND_SPAN, 5, 6, 0), 1, mk(0, 0, 0, 1, 0, 1)},
      '{rq(KIND_CLEAR, 0, 0, 0), 1, mk(0, 0, 0, 0, 0, 1)}
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[i]) begin
      send(dir_tab[i].req);
      if (dir_tab[i].chk && last_pred != dir_tab[i].want) begin
        $display("directed row %0d: table disagrees with predictor", i);
        errors++;
      end
    end
    // fill the pool with 1-column splits until it overflows, then split once more to overflow
    for (int c = 2; c < 140; c += 2) send(rq(KIND_SPAN, c, c + 1, 1));
    send(rq(KIND_SPAN, 200, 201, 1));
    send(rq(KIND_SPAN, 0, 511, 0));
    send(rq(KIND_CLEAR, 0, 0, 1));
    fork
      stall_receiver();
      for (int k = 0; k < 30; k++) send(rq(KIND_SPAN, k * 10, k * 10 + 7, 1));
    join
    for (int k = 0; k < N_RANDOM; k++) begin
      mode = $urandom_range(0, 99);
      if (mode < 4) r = rq(KIND_CLEAR, $urandom_range(0, 511), $urandom_range(0, 511),
                           $urandom_range(0, 1));
      else if (mode < 14) r = rq(KIND_SPAN, $urandom_range(0, 511), $urandom_range(0, 511),
                                 $urandom_range(0, 1));
      else begin
        a = $urandom_range(0, 319);
        w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 320) : $urandom_range(1, 12);
        r = rq(KIND_SPAN, a, a + w, $urandom_range(0, 3) != 0);
      end
      send(r);
    end
    s_tvalid_i <= 1'b0;
    while (pending_pieces.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("covered %0d items, %0d pieces, %0d pool overflows, %0d empty-set answers",
             n_items, n_pieces, n_ovf, n_done);
    if (errors == 0 && pending_pieces.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
